// ===== hdl/top_k_score_selector_core_defines.svh =====
// ----------------------------------------------------------------------------
// top_k_score_selector_core_defines.svh
// Assertion macros used by the selector core RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TKSEL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tksel assertion failed");

// next-cycle implication
`define TKSEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tksel assertion failed");

`endif

// ===== hdl/tksel_pkg.sv =====
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared types and constants of the top-k score selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

  localparam int SCORE_W   = 32;
  localparam int OUT_IDX_W = 16;
  localparam int RANK_W    = 4;
  localparam int CFG_W     = 5;
  localparam logic [CFG_W-1:0] SEL_COUNT_RESET = 5'd16;

  typedef logic [1:0] cell_mode_t;
  localparam cell_mode_t CELL_HOLD   = 2'd0;
  localparam cell_mode_t CELL_INSERT = 2'd1;
  localparam cell_mode_t CELL_SHIFT  = 2'd2;

  // per-cell control from the sequencer
  typedef struct packed {
    cell_mode_t mode;
    logic       occ;       // this cell holds a kept entry
    logic       prev_occ;  // left neighbor holds a kept entry (1 for the head)
  } cell_ctrl_t;

endpackage

// ===== hdl/tksel_cell.sv =====
// ----------------------------------------------------------------------------
// tksel_cell
// One slot of the sorted insertion chain.
// ----------------------------------------------------------------------------
module tksel_cell #(
  parameter int IDX_W = 16
) (
  input  logic                                clk,
  input  tksel_pkg::cell_ctrl_t               ctrl,
  input  logic signed [tksel_pkg::SCORE_W-1:0] new_score,
  input  logic        [IDX_W-1:0]             new_index,
  input  logic                                prev_ins,
  input  logic signed [tksel_pkg::SCORE_W-1:0] prev_score,
  input  logic        [IDX_W-1:0]             prev_index,
  input  logic signed [tksel_pkg::SCORE_W-1:0] next_score,
  input  logic        [IDX_W-1:0]             next_index,
  output logic                                ins,
  output logic signed [tksel_pkg::SCORE_W-1:0] score,
  output logic        [IDX_W-1:0]             index
);

  logic signed [tksel_pkg::SCORE_W-1:0] score_r, score_nxt;
  logic        [IDX_W-1:0]             index_r, index_nxt;

  // strictly lower kept score: the new pair goes in front of it
  assign ins = ctrl.occ && (score_r < new_score);

  always_comb begin
    score_nxt = score_r;
    index_nxt = index_r;
    case (ctrl.mode)
      tksel_pkg::CELL_INSERT: begin
        if (prev_ins) begin
          score_nxt = prev_score;
          index_nxt = prev_index;
        end else if (ins || (!ctrl.occ && ctrl.prev_occ)) begin
          score_nxt = new_score;
          index_nxt = new_index;
        end
      end
      tksel_pkg::CELL_SHIFT: begin
        score_nxt = next_score;
        index_nxt = next_index;
      end
      default: begin
        score_nxt = score_r;
        index_nxt = index_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    index_r <= index_nxt;
  end

  assign score = score_r;
  assign index = index_r;

endmodule

// ===== hdl/top_k_score_selector_core.sv =====
// ----------------------------------------------------------------------------
// top_k_score_selector_core
// Streaming top-k selection over (item index, score) requests.
// ----------------------------------------------------------------------------
// Usage: requests are taken one per cycle while the block collects a run; each
// goes into a chain of MAX_SELECT cells kept in descending score order, and
// ties keep arrival order. The request flagged last_item is itself a candidate
// and starts the drain: the kept entries leave best first, one per cycle as the
// output register frees, by shifting the chain toward its head. During the
// drain in_stall is high, so input is locked out until every kept entry has
// left (when nothing is kept, a single result with none_selected set is
// sent). The drain rate is set by the output handshake. The selection_count
// register is written through cfg_we / cfg_data; the user must write it only
// while idle; the block itself does not enforce this. Values above MAX_SELECT
// act as MAX_SELECT. Slots hold no reset value; only the kept ones are ever read.
// ----------------------------------------------------------------------------
`include "top_k_score_selector_core_defines.svh"

module top_k_score_selector_core #(
  parameter int MAX_SELECT = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic        [tksel_pkg::CFG_W-1:0]     cfg_data,
  // candidate requests
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic        [tksel_pkg::OUT_IDX_W-1:0] in_item_index,
  input  logic signed [tksel_pkg::SCORE_W-1:0]   in_score,
  input  logic                                   in_last_item,
  // selection results
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [tksel_pkg::OUT_IDX_W-1:0] out_selected_index,
  output logic signed [tksel_pkg::SCORE_W-1:0]   out_selected_score,
  output logic        [tksel_pkg::RANK_W-1:0]    out_rank,
  output logic                                   out_none_selected,
  output logic                                   out_last_in_run
);

  localparam int CNT_W = $clog2(MAX_SELECT + 1);

  // sequencer states
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                          state_r, state_nxt;
  logic [tksel_pkg::CFG_W-1:0]   sel_count_r;
  logic [CNT_W-1:0]              kept_r, kept_nxt;
  logic [CNT_W-1:0]              lim;
  logic [tksel_pkg::RANK_W-1:0]  rank_r, rank_nxt;

  logic in_acc;
  logic out_free;
  logic drain_go;
  logic drain_shift;
  logic placed;

  // chain wiring
  logic                          ins      [MAX_SELECT];
  logic signed [tksel_pkg::SCORE_W-1:0] c_score [MAX_SELECT];
  logic        [INDEX_BITS-1:0]         c_index [MAX_SELECT];
  logic        [MAX_SELECT-1:0]         ins_vec;
  tksel_pkg::cell_mode_t         mode;
  logic [INDEX_BITS-1:0]         new_index;

  // output register
  logic                                   out_valid_r, out_valid_nxt;
  logic        [tksel_pkg::OUT_IDX_W-1:0] out_index_r;
  logic signed [tksel_pkg::SCORE_W-1:0]   out_score_r;
  logic        [tksel_pkg::RANK_W-1:0]    out_rank_r;
  logic                                   out_none_r;
  logic                                   out_last_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign drain_go = (state_r == ST_DRAIN) && out_free;
  assign drain_shift = drain_go && (kept_r != '0);

  // effective capacity, saturated at the chain length
  always_comb begin
    if (int'(sel_count_r) > MAX_SELECT) begin
      lim = CNT_W'(MAX_SELECT);
    end else begin
      lim = CNT_W'(sel_count_r);
    end
  end

  assign new_index = INDEX_BITS'(in_item_index);

  always_comb begin
    if (in_acc) begin
      mode = tksel_pkg::CELL_INSERT;
    end else if (drain_shift) begin
      mode = tksel_pkg::CELL_SHIFT;
    end else begin
      mode = tksel_pkg::CELL_HOLD;
    end
  end

  // the insertion chain; each cell sees only its neighbors
  for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
    tksel_pkg::cell_ctrl_t ctrl;
    logic                                 p_ins;
    logic signed [tksel_pkg::SCORE_W-1:0] p_score, n_score;
    logic        [INDEX_BITS-1:0]         p_index, n_index;

    assign ctrl.mode = mode;
    assign ctrl.occ  = (CNT_W'(i) < kept_r);
    if (i == 0) begin : g_head
      assign ctrl.prev_occ = 1'b1;
      assign p_ins   = 1'b0;
      assign p_score = '0;
      assign p_index = '0;
    end else begin : g_body
      assign ctrl.prev_occ = (CNT_W'(i - 1) < kept_r);
      assign p_ins   = ins[i-1];
      assign p_score = c_score[i-1];
      assign p_index = c_index[i-1];
    end
    // the tail takes filler on a shift; it is empty afterward
    if (i == MAX_SELECT - 1) begin : g_tail
      assign n_score = '0;
      assign n_index = '0;
    end else begin : g_mid
      assign n_score = c_score[i+1];
      assign n_index = c_index[i+1];
    end

    tksel_cell #(
      .IDX_W(INDEX_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_score  (in_score),
      .new_index  (new_index),
      .prev_ins   (p_ins),
      .prev_score (p_score),
      .prev_index (p_index),
      .next_score (n_score),
      .next_index (n_index),
      .ins        (ins[i]),
      .score      (c_score[i]),
      .index      (c_index[i])
    );

    assign ins_vec[i] = ins[i];
  end

  assign placed = |ins_vec;

  // kept count: insertion drops the lowest entry once full, append stops at the limit
  always_comb begin
    kept_nxt = kept_r;
    if (in_acc) begin
      if (placed) begin
        if (({1'b0, kept_r} + 1'b1) <= {1'b0, lim}) begin
          kept_nxt = kept_r + 1'b1;
        end
      end else if (kept_r < lim) begin
        kept_nxt = kept_r + 1'b1;
      end
    end else if (drain_shift) begin
      kept_nxt = kept_r - 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    rank_nxt  = rank_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last_item) begin
          state_nxt = ST_DRAIN;
          rank_nxt  = '0;
        end
      end
      ST_DRAIN: begin
        if (drain_go) begin
          rank_nxt = rank_r + 1'b1;
          if (kept_r <= CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = drain_go ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_count_r <= tksel_pkg::SEL_COUNT_RESET;
      kept_r      <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        sel_count_r <= cfg_data;
      end
    end
  end

  // result payload: head of the chain, or the empty-run marker
  always_ff @(posedge clk) begin
    if (drain_go) begin
      if (kept_r == '0) begin
        out_index_r <= '0;
        out_score_r <= '0;
        out_rank_r  <= '0;
        out_none_r  <= 1'b1;
        out_last_r  <= 1'b1;
      end else begin
        out_index_r <= tksel_pkg::OUT_IDX_W'(c_index[0]);
        out_score_r <= c_score[0];
        out_rank_r  <= rank_r;
        out_none_r  <= 1'b0;
        out_last_r  <= (kept_r == CNT_W'(1));
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_index_r;
  assign out_selected_score = out_score_r;
  assign out_rank           = out_rank_r;
  assign out_none_selected  = out_none_r;
  assign out_last_in_run    = out_last_r;

  // checks
  `TKSEL_ASSERT_NOW(a_kept_bound, 1'b1, kept_r <= CNT_W'(MAX_SELECT))
  `TKSEL_ASSERT_NEXT(a_last_drains, in_acc && in_last_item, state_r == ST_DRAIN)
  `TKSEL_ASSERT_NOW(a_none_form, out_valid_r && out_none_r, out_last_r && (out_rank_r == '0) && (out_score_r == '0))
  `TKSEL_ASSERT_NEXT(a_idle_empty, (state_r == ST_DRAIN) && (state_nxt == ST_IDLE), kept_r == '0)

endmodule
